// ===== design/sme_pkg.sv =====
// ============================================================================
// sme_pkg: shared types and constants for the stack machine executor
// Opcodes, error codes, controller states and command/status structs.
// ============================================================================
`default_nettype none
package sme_pkg;

  // Instruction opcodes.
  localparam logic [4:0] OP_LIT = 5'd1;
  localparam logic [4:0] OP_RET = 5'd2;
  localparam logic [4:0] OP_LOD = 5'd3;
  localparam logic [4:0] OP_STO = 5'd4;
  localparam logic [4:0] OP_CAL = 5'd5;
  localparam logic [4:0] OP_INC = 5'd6;
  localparam logic [4:0] OP_JMP = 5'd7;
  localparam logic [4:0] OP_JPC = 5'd8;
  localparam logic [4:0] OP_WRT = 5'd9;
  localparam logic [4:0] OP_RED = 5'd10;
  localparam logic [4:0] OP_HLT = 5'd11;
  localparam logic [4:0] OP_NEG = 5'd12;
  localparam logic [4:0] OP_ADD = 5'd13;
  localparam logic [4:0] OP_SUB = 5'd14;
  localparam logic [4:0] OP_MUL = 5'd15;
  localparam logic [4:0] OP_DIV = 5'd16;
  localparam logic [4:0] OP_MOD = 5'd17;
  localparam logic [4:0] OP_EQL = 5'd18;
  localparam logic [4:0] OP_NEQ = 5'd19;
  localparam logic [4:0] OP_LSS = 5'd20;
  localparam logic [4:0] OP_LEQ = 5'd21;
  localparam logic [4:0] OP_GTR = 5'd22;
  localparam logic [4:0] OP_GEQ = 5'd23;

  // Error codes.
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_OVFL   = 3'd1;
  localparam logic [2:0] ERR_BOUNDS = 3'd2;
  localparam logic [2:0] ERR_BADOP  = 3'd3;
  localparam logic [2:0] ERR_DIVZ   = 3'd4;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK_RD,
    ST_WALK_WAIT,
    ST_ADDR,
    ST_MEM_WAIT,
    ST_RET_RD,
    ST_RET_WAIT,
    ST_CAL_WR1,
    ST_CAL_WR2,
    ST_DIV,
    ST_DONE,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture input item, fetch increment
    logic decode;     // latch register operands, run checks
    logic walk_init;  // start static link walk at frame base
    logic walk_rd;    // read stack at walk pointer
    logic walk_step;  // take the read data as new walk pointer
    logic addr_calc;  // form LOD/STO address and check it
    logic mem_rd;     // read stack at LOD address
    logic mem_wr;     // write register to stack at STO address
    logic lod_done;   // write LOD data to register
    logic ret_rd1;    // read saved frame base
    logic ret_rd2;    // read return address, check saved base
    logic ret_done;   // restore frame
    logic cal_wr0;    // write static link
    logic cal_wr1;    // write dynamic link
    logic cal_wr2;    // write return address, enter callee
    logic div_start;  // start divider
    logic simple;     // finish a simple instruction
    logic div_done;   // write divider result
    logic set_err;    // record err_code and halt
    logic [2:0] err_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [4:0] opcode;
    logic       halted;
    logic       idx_bad;   // a used register index out of range
    logic       walk_last; // no more levels to walk
    logic       walk_bad;  // walk pointer left the stack
    logic       addr_bad;  // LOD/STO address out of range
    logic       cal_low;   // stack pointer below three
    logic       ret_bad0;  // frame base below two
    logic       ret_bad1;  // saved frame base out of range
    logic       div_zero;
    logic       div_busy;
    logic       inc_err;   // INC error present
    logic [2:0] inc_code;
  } stat_t;

endpackage
`default_nettype wire

// ===== design/sme_ram.sv =====
// ============================================================================
// sme_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ============================================================================
`default_nettype none
module sme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== design/sme_div.sv =====
// ============================================================================
// sme_div: signed 32-bit divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ============================================================================
`default_nettype none
module sme_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient,
  output logic [31:0]      remainder
);
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        neg_q;
  logic        neg_r;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dsr};

  // One shift-subtract step per cycle on magnitudes.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= 6'd32;
      rem   <= '0;
      quo   <= dividend[31] ? (32'd0 - dividend) : dividend;
      dsr   <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg_q <= dividend[31] ^ divisor[31];
      neg_r <= dividend[31];
    end else if (busy) begin
      if (trial[32]) begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient  = neg_q ? (32'd0 - quo) : quo;
  assign remainder = neg_r ? (32'd0 - rem) : rem;
endmodule
`default_nettype wire

// ===== design/sme_datapath.sv =====
// ============================================================================
// sme_datapath: registers, stack memory and arithmetic of the executor
// Carries out the commands of the controller and reports status.
// ============================================================================
`default_nettype none
module sme_datapath #(
  parameter int STACK_DEPTH = 128,
  parameter int REG_COUNT   = 16,
  parameter int PC_WIDTH    = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sme_pkg::cmd_t cmd,
  output sme_pkg::stat_t     stat,
  input  wire logic [4:0]    opcode,
  input  wire logic [3:0]    field_r,
  input  wire logic [3:0]    field_l,
  input  wire logic [31:0]   field_m,
  input  wire logic [31:0]   read_value,
  output logic [15:0]        next_pc,
  output logic               halted,
  output logic [2:0]         error_code,
  output logic               write_valid,
  output logic [31:0]        write_value
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [7:0] DEPTH8 = 8'(STACK_DEPTH);

  // Captured instruction.
  logic [4:0]  op;
  logic [3:0]  fr;
  logic [3:0]  fl;
  logic [31:0] fm;
  logic [31:0] rdv;

  // Architectural state.
  logic [31:0] rf [REG_COUNT];
  logic [REG_COUNT-1:0] rf_ok;  // entry written since reset
  logic [STACK_DEPTH-1:0] st_ok;
  logic [PC_WIDTH-1:0] pc;
  logic [7:0] sp;
  logic [7:0] bp;
  logic       hlt;

  // Working registers.
  logic [31:0] xa;      // RF[r]
  logic [31:0] xl;      // RF[l]
  logic [31:0] xm;      // RF[m]
  logic [31:0] wp;      // walk pointer / LOD-STO base
  logic [3:0]  lv;      // levels left
  logic [31:0] sbase;   // saved frame base during RET
  logic [AW-1:0] rd_addr;

  // Stack memory port.
  logic          m_we;
  logic [AW-1:0] m_addr;
  logic [31:0]   m_wd;
  logic [31:0]   m_rq;
  logic [31:0]   m_rd;

  sme_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk  (clk),
    .we   (m_we),
    .addr (m_addr),
    .wdata(m_wd),
    .rdata(m_rq)
  );

  // Unwritten stack entries read as zero.
  assign m_rd = st_ok[rd_addr] ? m_rq : 32'd0;

  // Divider.
  logic        dv_busy;
  logic [31:0] dv_q;
  logic [31:0] dv_r;

  sme_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (xl),
    .divisor  (xm),
    .busy     (dv_busy),
    .quotient (dv_q),
    .remainder(dv_r)
  );

  // Register reads and index checks.
  logic r_bad;
  logic l_bad;
  logic m_bad;
  logic [31:0] ra;
  logic [31:0] rl;
  logic [31:0] rm;

  assign r_bad = ({28'd0, fr} >= 32'(REG_COUNT));
  assign l_bad = ({28'd0, fl} >= 32'(REG_COUNT));
  assign m_bad = (fm >= 32'(REG_COUNT));
  assign ra = (!r_bad && rf_ok[fr[RW-1:0]]) ? rf[fr[RW-1:0]] : 32'd0;
  assign rl = (!l_bad && rf_ok[fl[RW-1:0]]) ? rf[fl[RW-1:0]] : 32'd0;
  assign rm = (!m_bad && rf_ok[fm[RW-1:0]]) ? rf[fm[RW-1:0]] : 32'd0;

  // Checks reported to the controller.
  // The LOD/STO address is formed at 33 bits so that a walked base far from
  // the stack cannot wrap back into range.
  logic [32:0] inc_addr;
  logic [32:0] lds_addr;

  assign inc_addr = {25'd0, sp} - {fm[31], fm};
  assign lds_addr = {wp[31], wp} - {xm[31], xm};

  always_comb begin
    stat = '0;
    stat.opcode    = op;
    stat.halted    = hlt;
    stat.walk_last = (lv == 4'd0);
    stat.walk_bad  = wp[31] || (wp >= 32'(STACK_DEPTH));
    stat.addr_bad  = lds_addr[32] || (lds_addr[31:0] >= 32'(STACK_DEPTH));
    stat.cal_low   = (sp < 8'd3);
    stat.ret_bad0  = (bp < 8'd2);
    stat.ret_bad1  = (sbase >= 32'(STACK_DEPTH));
    stat.div_zero  = (xm == 32'd0);
    stat.div_busy  = dv_busy;
    stat.inc_err   = inc_addr[32] || ($signed(inc_addr) > $signed(33'(STACK_DEPTH)));
    stat.inc_code  = inc_addr[32] ? sme_pkg::ERR_OVFL : sme_pkg::ERR_BOUNDS;
    unique case (op)
      sme_pkg::OP_LIT, sme_pkg::OP_JPC, sme_pkg::OP_WRT, sme_pkg::OP_RED,
      sme_pkg::OP_NEG: stat.idx_bad = r_bad;
      sme_pkg::OP_LOD, sme_pkg::OP_STO: stat.idx_bad = r_bad || m_bad;
      default: stat.idx_bad = r_bad || l_bad || m_bad;
    endcase
  end

  // Stack port address and data selection.
  always_comb begin
    m_we   = 1'b0;
    m_wd   = xa;
    m_addr = wp[AW-1:0];
    if (cmd.mem_wr) begin
      m_we = 1'b1;
      m_addr = lds_addr[AW-1:0];
    end else if (cmd.mem_rd) begin
      m_addr = lds_addr[AW-1:0];
    end else if (cmd.ret_rd1) begin
      m_addr = AW'(bp - 8'd1);
    end else if (cmd.ret_rd2) begin
      m_addr = AW'(bp - 8'd2);
    end else if (cmd.cal_wr0) begin
      m_we = 1'b1;
      m_addr = AW'(sp - 8'd1);
      m_wd = wp;
    end else if (cmd.cal_wr1) begin
      m_we = 1'b1;
      m_addr = AW'(sp - 8'd2);
      m_wd = {24'd0, bp};
    end else if (cmd.cal_wr2) begin
      m_we = 1'b1;
      m_addr = AW'(sp - 8'd3);
      m_wd = 32'(pc);
    end
  end

  // ALU for simple register instructions.
  logic [31:0] mul_res;
  logic [31:0] alu;

  assign mul_res = xl * xm;

  always_comb begin
    case (op)
      sme_pkg::OP_ADD: alu = xl + xm;
      sme_pkg::OP_SUB: alu = xl - xm;
      sme_pkg::OP_MUL: alu = mul_res;
      sme_pkg::OP_EQL: alu = {31'd0, xl == xm};
      sme_pkg::OP_NEQ: alu = {31'd0, xl != xm};
      sme_pkg::OP_LSS: alu = {31'd0, $signed(xl) < $signed(xm)};
      sme_pkg::OP_LEQ: alu = {31'd0, $signed(xl) <= $signed(xm)};
      sme_pkg::OP_GTR: alu = {31'd0, $signed(xl) > $signed(xm)};
      sme_pkg::OP_GEQ: alu = {31'd0, $signed(xl) >= $signed(xm)};
      sme_pkg::OP_NEG: alu = 32'd0 - xa;
      sme_pkg::OP_RED: alu = rdv;
      default:         alu = fm;
    endcase
  end

  // State update.
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_ok <= '0;
      st_ok <= '0;
      pc    <= '0;
      sp    <= DEPTH8;
      bp    <= DEPTH8 - 8'd1;
      hlt   <= 1'b0;
      error_code  <= sme_pkg::ERR_NONE;
      write_valid <= 1'b0;
      write_value <= '0;
    end else begin
      if (cmd.load) begin
        op  <= opcode;
        fr  <= field_r;
        fl  <= field_l;
        fm  <= field_m;
        rdv <= read_value;
        error_code  <= sme_pkg::ERR_NONE;
        write_valid <= 1'b0;
        write_value <= '0;
        if (!hlt) begin
          pc <= pc + 1'b1;
        end
      end
      if (cmd.decode) begin
        xa <= ra;
        xl <= rl;
        xm <= rm;
        lv <= fl;
        wp <= {24'd0, bp};
      end
      if (cmd.walk_init) begin
        wp <= {24'd0, bp};
      end
      if (cmd.walk_rd) begin
        rd_addr <= wp[AW-1:0];
      end
      if (cmd.walk_step) begin
        wp <= m_rd;
        lv <= lv - 4'd1;
      end
      if (cmd.addr_calc) begin
        wp <= wp;
      end
      if (cmd.mem_rd) begin
        rd_addr <= lds_addr[AW-1:0];
      end
      if (cmd.mem_wr) begin
        st_ok[lds_addr[AW-1:0]] <= 1'b1;
      end
      if (cmd.lod_done) begin
        rf[fr[RW-1:0]] <= m_rd;
        rf_ok[fr[RW-1:0]] <= 1'b1;
      end
      if (cmd.ret_rd1) begin
        rd_addr <= AW'(bp - 8'd1);
      end
      if (cmd.ret_rd2) begin
        rd_addr <= AW'(bp - 8'd2);
        sbase <= m_rd;
      end
      if (cmd.ret_done) begin
        sp <= bp + 8'd1;
        pc <= m_rd[PC_WIDTH-1:0];
        bp <= sbase[7:0];
      end
      if (cmd.cal_wr0) begin
        st_ok[AW'(sp - 8'd1)] <= 1'b1;
      end
      if (cmd.cal_wr1) begin
        st_ok[AW'(sp - 8'd2)] <= 1'b1;
      end
      if (cmd.cal_wr2) begin
        st_ok[AW'(sp - 8'd3)] <= 1'b1;
        bp <= sp - 8'd1;
        pc <= fm[PC_WIDTH-1:0];
      end
      if (cmd.simple) begin
        case (op)
          sme_pkg::OP_JMP: pc <= fm[PC_WIDTH-1:0];
          sme_pkg::OP_JPC: begin
            if (xa == 32'd0) begin
              pc <= fm[PC_WIDTH-1:0];
            end
          end
          sme_pkg::OP_WRT: begin
            write_valid <= 1'b1;
            write_value <= xa;
          end
          sme_pkg::OP_HLT: hlt <= 1'b1;
          sme_pkg::OP_INC: sp <= inc_addr[7:0];
          sme_pkg::OP_LIT, sme_pkg::OP_RED, sme_pkg::OP_NEG, sme_pkg::OP_ADD,
          sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_EQL, sme_pkg::OP_NEQ,
          sme_pkg::OP_LSS, sme_pkg::OP_LEQ, sme_pkg::OP_GTR,
          sme_pkg::OP_GEQ: begin
            rf[fr[RW-1:0]] <= alu;
            rf_ok[fr[RW-1:0]] <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.div_done) begin
        rf[fr[RW-1:0]] <= (op == sme_pkg::OP_DIV) ? dv_q : dv_r;
        rf_ok[fr[RW-1:0]] <= 1'b1;
      end
      if (cmd.set_err) begin
        error_code <= cmd.err_code;
        hlt <= 1'b1;
      end
    end
  end

  assign next_pc = 16'(pc);
  assign halted  = hlt;
endmodule
`default_nettype wire

// ===== design/sme_ctrl.sv =====
// ============================================================================
// sme_ctrl: instruction sequencer of the executor
// Steps each instruction through decode, link walk, memory and divide.
// ============================================================================
`default_nettype none
module sme_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output sme_pkg::cmd_t       cmd,
  input  wire sme_pkg::stat_t stat
);
  sme_pkg::state_t state;
  sme_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sme_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      sme_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = sme_pkg::ST_DECODE;
        end
      end
      sme_pkg::ST_DECODE: begin
        cmd.decode = 1'b1;
        state_next = sme_pkg::ST_DONE;
        if (stat.halted) begin
          state_next = sme_pkg::ST_OUT;
        end else begin
          unique case (stat.opcode)
            sme_pkg::OP_LOD, sme_pkg::OP_STO, sme_pkg::OP_CAL, sme_pkg::OP_RET,
            sme_pkg::OP_DIV, sme_pkg::OP_MOD, sme_pkg::OP_INC, sme_pkg::OP_JMP,
            sme_pkg::OP_JPC, sme_pkg::OP_WRT, sme_pkg::OP_RED, sme_pkg::OP_HLT,
            sme_pkg::OP_NEG, sme_pkg::OP_LIT, sme_pkg::OP_ADD, sme_pkg::OP_SUB,
            sme_pkg::OP_MUL, sme_pkg::OP_EQL, sme_pkg::OP_NEQ, sme_pkg::OP_LSS,
            sme_pkg::OP_LEQ, sme_pkg::OP_GTR, sme_pkg::OP_GEQ: ;
            default: begin
              cmd.set_err = 1'b1;
              cmd.err_code = sme_pkg::ERR_BADOP;
              state_next = sme_pkg::ST_OUT;
            end
          endcase
          if (stat.opcode == sme_pkg::OP_RET) begin
            if (stat.ret_bad0) begin
              cmd.set_err = 1'b1;
              cmd.err_code = sme_pkg::ERR_BOUNDS;
              state_next = sme_pkg::ST_OUT;
            end else begin
              state_next = sme_pkg::ST_RET_RD;
            end
          end
          if (stat.opcode == sme_pkg::OP_CAL) begin
            if (stat.cal_low) begin
              cmd.set_err = 1'b1;
              cmd.err_code = sme_pkg::ERR_OVFL;
              state_next = sme_pkg::ST_OUT;
            end else begin
              state_next = sme_pkg::ST_WALK_RD;
            end
          end
        end
      end
      sme_pkg::ST_WALK_RD: begin
        if (stat.opcode != sme_pkg::OP_CAL && stat.idx_bad) begin
          cmd.set_err = 1'b1;
          cmd.err_code = sme_pkg::ERR_BOUNDS;
          state_next = sme_pkg::ST_OUT;
        end else if (stat.walk_last) begin
          state_next = (stat.opcode == sme_pkg::OP_CAL) ? sme_pkg::ST_CAL_WR1
                                                         : sme_pkg::ST_ADDR;
          cmd.cal_wr0 = (stat.opcode == sme_pkg::OP_CAL);
        end else if (stat.walk_bad) begin
          cmd.set_err = 1'b1;
          cmd.err_code = sme_pkg::ERR_BOUNDS;
          state_next = sme_pkg::ST_OUT;
        end else begin
          cmd.walk_rd = 1'b1;
          state_next = sme_pkg::ST_WALK_WAIT;
        end
      end
      sme_pkg::ST_WALK_WAIT: begin
        cmd.walk_step = 1'b1;
        state_next = sme_pkg::ST_WALK_RD;
      end
      sme_pkg::ST_ADDR: begin
        cmd.addr_calc = 1'b1;
        if (stat.addr_bad) begin
          cmd.set_err = 1'b1;
          cmd.err_code = sme_pkg::ERR_BOUNDS;
          state_next = sme_pkg::ST_OUT;
        end else if (stat.opcode == sme_pkg::OP_STO) begin
          cmd.mem_wr = 1'b1;
          state_next = sme_pkg::ST_OUT;
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = sme_pkg::ST_MEM_WAIT;
        end
      end
      sme_pkg::ST_MEM_WAIT: begin
        cmd.lod_done = 1'b1;
        state_next = sme_pkg::ST_OUT;
      end
      sme_pkg::ST_RET_RD: begin
        cmd.ret_rd1 = 1'b1;
        state_next = sme_pkg::ST_RET_WAIT;
      end
      sme_pkg::ST_RET_WAIT: begin
        cmd.ret_rd2 = 1'b1;
        state_next = sme_pkg::ST_CAL_WR2;
      end
      sme_pkg::ST_CAL_WR1: begin
        cmd.cal_wr1 = 1'b1;
        state_next = sme_pkg::ST_CAL_WR2;
      end
      sme_pkg::ST_CAL_WR2: begin
        state_next = sme_pkg::ST_OUT;
        if (stat.opcode == sme_pkg::OP_CAL) begin
          cmd.cal_wr2 = 1'b1;
        end else if (stat.ret_bad1) begin
          cmd.set_err = 1'b1;
          cmd.err_code = sme_pkg::ERR_BOUNDS;
        end else begin
          cmd.ret_done = 1'b1;
        end
      end
      sme_pkg::ST_DIV: begin
        if (!stat.div_busy) begin
          cmd.div_done = 1'b1;
          state_next = sme_pkg::ST_OUT;
        end
      end
      sme_pkg::ST_DONE: begin
        state_next = sme_pkg::ST_OUT;
        if (stat.opcode == sme_pkg::OP_LOD || stat.opcode == sme_pkg::OP_STO) begin
          state_next = sme_pkg::ST_WALK_RD;
        end else if (stat.idx_bad && stat.opcode != sme_pkg::OP_INC &&
                     stat.opcode != sme_pkg::OP_JMP && stat.opcode != sme_pkg::OP_HLT) begin
          cmd.set_err = 1'b1;
          cmd.err_code = sme_pkg::ERR_BOUNDS;
        end else if (stat.opcode == sme_pkg::OP_INC && stat.inc_err) begin
          cmd.set_err = 1'b1;
          cmd.err_code = stat.inc_code;
        end else if (stat.opcode == sme_pkg::OP_DIV || stat.opcode == sme_pkg::OP_MOD) begin
          if (stat.div_zero) begin
            cmd.set_err = 1'b1;
            cmd.err_code = sme_pkg::ERR_DIVZ;
          end else begin
            cmd.div_start = 1'b1;
            state_next = sme_pkg::ST_DIV;
          end
        end else begin
          cmd.simple = 1'b1;
        end
      end
      sme_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = sme_pkg::ST_IDLE;
        end
      end
      default: state_next = sme_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/stack_machine_executor_unit.sv =====
// ============================================================================
// stack_machine_executor_unit: PM/0 style stack machine instruction executor
// Top level joining the sequencer and the datapath.
// ============================================================================
// Usage: each request on the input channel (in_valid/in_stall) carries one
// instruction: opcode, field_r, field_l, field_m and read_value. The unit
// returns exactly one result per request on the output channel
// (out_valid/out_stall): next_pc, halted, error_code, write_valid and
// write_value.
// Each accepted instruction is decoded; simple ones then finish in the done
// state. LOD and STO walk the static links, form and check the address,
// and LOD reads the stack; CAL walks the links and writes three link words;
// RET reads two saved words; DIV and MOD run in the bit-serial divider. A
// halted machine, a bad opcode or a failed CAL or RET check in decode
// answers straight from decode. One stack memory port with registered reads
// sets the memory instruction cost. One instruction is in flight at a time
// and the next request is taken the cycle after the result is accepted.
// Reset clears the registers to zero, PC to zero, SP to the stack depth
// and BP to depth minus one; stack memory reads as zero until written.
// While the receiver stalls, the result holds and no new request is taken.
// ============================================================================
`default_nettype none
module stack_machine_executor_unit #(
  parameter int STACK_DEPTH = 128,
  parameter int REG_COUNT   = 16,
  parameter int PC_WIDTH    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [4:0]  opcode,
  input  wire logic [3:0]  field_r,
  input  wire logic [3:0]  field_l,
  input  wire logic [31:0] field_m,
  input  wire logic [31:0] read_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      next_pc,
  output logic             halted,
  output logic [2:0]       error_code,
  output logic             write_valid,
  output logic [31:0]      write_value
);
  sme_pkg::cmd_t  cmd;
  sme_pkg::stat_t stat;

  sme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  sme_datapath #(
    .STACK_DEPTH(STACK_DEPTH),
    .REG_COUNT  (REG_COUNT),
    .PC_WIDTH   (PC_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .opcode     (opcode),
    .field_r    (field_r),
    .field_l    (field_l),
    .field_m    (field_m),
    .read_value (read_value),
    .next_pc    (next_pc),
    .halted     (halted),
    .error_code (error_code),
    .write_valid(write_valid),
    .write_value(write_value)
  );
endmodule
`default_nettype wire

// ===== design/sme_checker.sv =====
// ============================================================================
// sme_checker: port checks for the stack machine executor
// Watches the handshake and result fields over time.
// ============================================================================
`default_nettype none
module sme_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        halted,
  input wire logic [2:0]  error_code,
  input wire logic        write_valid,
  input wire logic [31:0] write_value
);
  // No request is taken while a result is offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken during result");

  // An error always reports the halted state.
  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != sme_pkg::ERR_NONE) |-> halted)
    else $error("error without halt");

  // Once halted, the unit stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(halted) && !$past(rst) |-> halted) else $error("halt released");

  // A written value never comes with an error.
  a_wrt_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_valid) |-> (error_code == sme_pkg::ERR_NONE))
    else $error("write with error");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && out_stall) && !$past(rst) |-> out_valid && $stable(write_value))
    else $error("stalled result changed");
endmodule

bind stack_machine_executor_unit sme_checker u_sme_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .halted     (halted),
  .error_code (error_code),
  .write_valid(write_valid),
  .write_value(write_value)
);
`default_nettype wire
